// ----- rtl/ilie_pkg.sv -----
// shared types, widths and codes for the indexed list insert/erase unit
// no dependencies; every other file uses this package by scoped names
package ilie_pkg;

  localparam int DEPTH      = 16;
  localparam int WORD_WIDTH = 32;

  // fixed field widths of the stream payload
  localparam int KIND_W   = 2;
  localparam int POS_W    = 5;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // internal widths
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int EXT_W = (WORD_WIDTH > VALUE_W) ? WORD_WIDTH : VALUE_W;

  localparam int IN_DATA_W  = ((POS_W + VALUE_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((STATUS_W + VALUE_W + COUNT_W + 7) / 8) * 8;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;  // capture the incoming request
    logic exec;  // carry out the captured request and load the result
  } dp_cmd_t;

endpackage

// ----- rtl/ilie_ctrl.sv -----
// controller state machine for the indexed list insert/erase unit
// depends on ilie_pkg (command struct)
module ilie_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output ilie_pkg::dp_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;
  logic accept;

  // a new item may enter in the idle state once the result slot is free or draining
  assign s_tready = (state == S_IDLE) && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    cmd            = '0;
    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec       = 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/ilie_datapath.sv -----
// list storage, request registers and result registers
// depends on ilie_pkg (widths, codes, command struct)
module ilie_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  ilie_pkg::dp_cmd_t                 cmd,
  input  logic [ilie_pkg::KIND_W-1:0]       kind,
  input  logic [ilie_pkg::POS_W-1:0]        position,
  input  logic signed [ilie_pkg::VALUE_W-1:0] value,
  output logic [ilie_pkg::STATUS_W-1:0]     status,
  output logic signed [ilie_pkg::VALUE_W-1:0] read_value,
  output logic [ilie_pkg::COUNT_W-1:0]      count
);

  logic [ilie_pkg::KIND_W-1:0]     req_kind;
  logic [ilie_pkg::CMP_W-1:0]      req_pos;
  logic [ilie_pkg::WORD_WIDTH-1:0] req_word;

  logic [ilie_pkg::WORD_WIDTH-1:0] entries [ilie_pkg::DEPTH];
  logic [ilie_pkg::WORD_WIDTH-1:0] entries_next [ilie_pkg::DEPTH];
  logic [ilie_pkg::CNT_W-1:0]      held_count;
  logic [ilie_pkg::CNT_W-1:0]      held_count_next;

  logic [ilie_pkg::CMP_W-1:0]      held_ext;
  logic                            full;
  logic [ilie_pkg::STATUS_W-1:0]   status_next;
  logic [ilie_pkg::VALUE_W-1:0]    rd_next;
  logic [ilie_pkg::WORD_WIDTH-1:0] rd_word;
  logic signed [ilie_pkg::EXT_W-1:0] rd_ext;

  assign held_ext = ilie_pkg::CMP_W'(held_count);
  assign full     = (held_count == ilie_pkg::CNT_W'(ilie_pkg::DEPTH));
  assign rd_word  = entries[req_pos[ilie_pkg::IDX_W-1:0]];
  assign rd_ext   = ilie_pkg::EXT_W'(signed'(rd_word));

  always_comb begin
    status_next     = ilie_pkg::ST_DONE;
    rd_next         = '0;
    held_count_next = held_count;
    for (int i = 0; i < ilie_pkg::DEPTH; i++) begin
      entries_next[i] = entries[i];
    end
    case (req_kind)
      ilie_pkg::KIND_APPEND: begin
        if (full) begin
          status_next = ilie_pkg::ST_FULL;
        end else begin
          for (int i = 0; i < ilie_pkg::DEPTH; i++) begin
            if (ilie_pkg::CMP_W'(i) == held_ext) entries_next[i] = req_word;
          end
          held_count_next = held_count + 1'b1;
        end
      end
      ilie_pkg::KIND_INSERT: begin
        if (req_pos > held_ext) begin
          status_next = ilie_pkg::ST_RANGE;
        end else if (full) begin
          status_next = ilie_pkg::ST_FULL;
        end else begin
          // every entry at or past the position moves up one cell
          for (int i = 0; i < ilie_pkg::DEPTH; i++) begin
            if (ilie_pkg::CMP_W'(i) == req_pos) begin
              entries_next[i] = req_word;
            end else if (i > 0 && ilie_pkg::CMP_W'(i) > req_pos &&
                         ilie_pkg::CMP_W'(i) <= held_ext) begin
              entries_next[i] = entries[(i > 0) ? i - 1 : 0];
            end
          end
          held_count_next = held_count + 1'b1;
        end
      end
      ilie_pkg::KIND_ERASE: begin
        if (req_pos >= held_ext) begin
          status_next = ilie_pkg::ST_RANGE;
        end else begin
          // later entries move down one cell
          for (int i = 0; i < ilie_pkg::DEPTH - 1; i++) begin
            if (ilie_pkg::CMP_W'(i) >= req_pos &&
                ilie_pkg::CMP_W'(i + 1) < held_ext) begin
              entries_next[i] = entries[i + 1];
            end
          end
          held_count_next = held_count - 1'b1;
        end
      end
      default: begin
        if (req_pos >= held_ext) begin
          status_next = ilie_pkg::ST_RANGE;
        end else begin
          rd_next = rd_ext[ilie_pkg::VALUE_W-1:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind <= kind;
      req_pos  <= ilie_pkg::CMP_W'(position);
      req_word <= ilie_pkg::WORD_WIDTH'($unsigned(value));
    end
    if (cmd.exec) begin
      for (int i = 0; i < ilie_pkg::DEPTH; i++) begin
        entries[i] <= entries_next[i];
      end
      status     <= status_next;
      read_value <= signed'(rd_next);
      count      <= ilie_pkg::COUNT_W'(held_count_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= '0;
    end else if (cmd.exec) begin
      held_count <= held_count_next;
    end
  end

endmodule

// ----- rtl/indexed_list_insert_erase_unit.sv -----
// indexed list insert/erase unit: ordered list of signed words with append,
// insert, erase and read at a position; one result item per request item
// a result becomes valid after the controller's capture then execute steps; a new item
// is taken only after the previous one is executed and while the result slot is free or draining
// reset (rst, synchronous, active high) empties the list and the result slot
// depends on ilie_pkg, ilie_ctrl and ilie_datapath
module indexed_list_insert_erase_unit (
  input  logic                                clk,
  input  logic                                rst,
  // request stream
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [ilie_pkg::IN_DATA_W-1:0]      s_tdata,  // position[4:0], value[36:5], zero pad
  input  logic [ilie_pkg::KIND_W-1:0]         s_tuser,  // kind[1:0]
  // result stream
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [ilie_pkg::OUT_DATA_W-1:0]     m_tdata   // status[1:0], read_value[33:2],
                                                        // count[38:34], zero pad
);

  ilie_pkg::dp_cmd_t cmd;

  logic [ilie_pkg::POS_W-1:0]          in_position;
  logic signed [ilie_pkg::VALUE_W-1:0] in_value;
  logic [ilie_pkg::STATUS_W-1:0]       res_status;
  logic signed [ilie_pkg::VALUE_W-1:0] res_read_value;
  logic [ilie_pkg::COUNT_W-1:0]        res_count;

  // unpack the request item
  assign in_position = s_tdata[ilie_pkg::POS_W-1:0];
  assign in_value    = signed'(s_tdata[ilie_pkg::POS_W +: ilie_pkg::VALUE_W]);

  // sequencing: capture one item, execute it, hold its result until taken
  ilie_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  // list cells shift all at once, so each request completes in the controller's execute state
  ilie_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .kind       (s_tuser),
    .position   (in_position),
    .value      (in_value),
    .status     (res_status),
    .read_value (res_read_value),
    .count      (res_count)
  );

  // pack the result item, upper bits zero
  assign m_tdata = ilie_pkg::OUT_DATA_W'({res_count, res_read_value, res_status});

endmodule

// ----- bench/indexed_list_insert_erase_unit_tb.sv -----
`timescale 1ns / 100ps
// self-checking bench for indexed_list_insert_erase_unit: random bursty requests against
// a behavioral copy of the list, results checked field by field in arrival order
// depends on ilie_pkg and the unit's rtl
module indexed_list_insert_erase_unit_tb;

  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest correct run
  localparam int RANDOM_ITEMS = 1830;
  localparam int SETTLE_WAIT  = 12;      // result follows accept after the capture and execute steps, leave margin
  localparam int HOLD_OFF_LEN = 200;     // long receiver stall, fills the result slot
  localparam int MAX_PRINTS   = 40;

  // one request and one result as the bench sees them
  typedef struct {
    logic [ilie_pkg::KIND_W-1:0]  kind;
    logic [ilie_pkg::POS_W-1:0]   pos;
    logic [ilie_pkg::VALUE_W-1:0] value;
    bit                           wait_drain;  // hold this item back until nothing is outstanding
  } list_req_t;

  typedef struct {
    logic [ilie_pkg::STATUS_W-1:0] status;
    logic [ilie_pkg::VALUE_W-1:0]  read_value;
    logic [ilie_pkg::COUNT_W-1:0]  count;
  } list_resp_t;

  // receiver stall patterns, switched every so often
  typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_t;

  // stimulus phases that steer the list size up, down or around
  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} gen_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [ilie_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
  logic [ilie_pkg::KIND_W-1:0]     s_tuser  = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [ilie_pkg::OUT_DATA_W-1:0] m_tdata;

  indexed_list_insert_erase_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  list_req_t  pending_reqs[$];
  list_resp_t awaited_results[$];

  // shadow copy of the list
  logic signed [ilie_pkg::WORD_WIDTH-1:0] list_words[ilie_pkg::DEPTH];
  int held_entries = 0;

  int cycle_count     = 0;
  int mismatch_count  = 0;
  int results_checked = 0;
  int kind_totals[4]   = '{default: 0};
  int status_totals[4] = '{default: 0};

  // ---------------------------------------------------------------------------
  // list behavior: apply one request to the shadow list, return its result
  // ---------------------------------------------------------------------------
  function automatic list_resp_t apply_list_op(list_req_t r);
    list_resp_t rsp;
    int p;
    int i;
    p = int'(r.pos);
    rsp.status     = ilie_pkg::ST_DONE;
    rsp.read_value = '0;
    case (r.kind)
      ilie_pkg::KIND_APPEND: begin
        if (held_entries >= ilie_pkg::DEPTH) begin
          rsp.status = ilie_pkg::ST_FULL;
        end else begin
          list_words[held_entries] = r.value;
          held_entries++;
        end
      end
      ilie_pkg::KIND_INSERT: begin
        // position is checked before capacity
        if (p > held_entries) begin
          rsp.status = ilie_pkg::ST_RANGE;
        end else if (held_entries >= ilie_pkg::DEPTH) begin
          rsp.status = ilie_pkg::ST_FULL;
        end else begin
          for (i = held_entries; i > p; i--) list_words[i] = list_words[i-1];
          list_words[p] = r.value;
          held_entries++;
        end
      end
      ilie_pkg::KIND_ERASE: begin
        if (p >= held_entries) begin
          rsp.status = ilie_pkg::ST_RANGE;
        end else begin
          for (i = p; i + 1 < held_entries; i++) list_words[i] = list_words[i+1];
          held_entries--;
        end
      end
      default: begin
        // read sign-extends the stored word into the result field
        if (p >= held_entries) rsp.status = ilie_pkg::ST_RANGE;
        else rsp.read_value = list_words[p];
      end
    endcase
    rsp.count = held_entries[ilie_pkg::COUNT_W-1:0];
    return rsp;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    if (mismatch_count < MAX_PRINTS)
      $display("mismatch @%0d: %s got %0h want %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_req(input logic [ilie_pkg::KIND_W-1:0] kind, input int pos,
                           input logic [ilie_pkg::VALUE_W-1:0] value, input bit wait_drain);
    list_req_t r;
    r.kind       = kind;
    r.pos        = pos[ilie_pkg::POS_W-1:0];
    r.value      = value;
    r.wait_drain = wait_drain;
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // ---------------------------------------------------------------------------
  // request driver: bursts of random length, random gaps, holds an offered item
  // ---------------------------------------------------------------------------
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    logic                           offer;
    logic [ilie_pkg::IN_DATA_W-1:0] word;
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left = $urandom_range(1, 30);
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        kind_totals[pending_reqs[0].kind]++;
        awaited_results.insert(awaited_results.size(), apply_list_op(pending_reqs[0]));
        void'(pending_reqs.pop_front());
      end
      offer = 1'b0;
      if (s_tvalid && !s_tready) begin
        offer = 1'b1;  // an offered item stays until taken
      end else if (pending_reqs.size() != 0) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!(pending_reqs[0].wait_drain && awaited_results.size() != 0)) begin
          offer = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            // about a quarter of bursts run straight into the next one
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      if (offer) begin
        word                                   = '0;
        word[ilie_pkg::POS_W-1:0]              = pending_reqs[0].pos;
        word[ilie_pkg::POS_W+:ilie_pkg::VALUE_W] = pending_reqs[0].value;
        s_tdata                                <= word;
        s_tuser                                <= pending_reqs[0].kind;
      end
      s_tvalid <= offer;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver stalls
  // ---------------------------------------------------------------------------
  rx_style_t rx_style = RX_STEADY;
  int        hold_left = 0;

  always @(posedge clk) begin
    list_resp_t want;
    logic       ready_next;
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          flag_mismatch("result with none outstanding", 64'(m_tdata), '0);
        end else begin
          want = awaited_results.pop_front();
          status_totals[want.status]++;
          if (m_tdata[ilie_pkg::STATUS_W-1:0] !== want.status)
            flag_mismatch("status", 64'(m_tdata[ilie_pkg::STATUS_W-1:0]),
                          64'(want.status));
          if (m_tdata[ilie_pkg::STATUS_W+:ilie_pkg::VALUE_W] !== want.read_value)
            flag_mismatch("read_value", 64'(m_tdata[ilie_pkg::STATUS_W+:ilie_pkg::VALUE_W]),
                          64'(want.read_value));
          if (m_tdata[ilie_pkg::STATUS_W+ilie_pkg::VALUE_W+:ilie_pkg::COUNT_W] !== want.count)
            flag_mismatch("count",
                          64'(m_tdata[ilie_pkg::STATUS_W+ilie_pkg::VALUE_W+:ilie_pkg::COUNT_W]),
                          64'(want.count));
        end
        results_checked++;
        // two long hold-offs so the unit backs up into its input
        if (results_checked == 250 || results_checked == 1100) hold_left = HOLD_OFF_LEN;
      end
      if (cycle_count % 97 == 0) rx_style = rx_style_t'($urandom_range(0, 3));
      if (hold_left > 0) begin
        hold_left--;
        ready_next = 1'b0;
      end else begin
        case (rx_style)
          RX_STEADY:   ready_next = 1'b1;
          RX_COIN:     ready_next = ($urandom_range(0, 1) == 1);
          RX_SPARSE:   ready_next = ($urandom_range(0, 3) == 0);
          default:     ready_next = (cycle_count % 5) < 3;
        endcase
      end
      m_tready <= ready_next;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, awaited_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    gen_mode_t                    mode;
    int                           phase_left;
    int                           phase_num;
    int                           pick;
    int                           pos;
    logic [ilie_pkg::KIND_W-1:0]  kind;
    logic [ilie_pkg::VALUE_W-1:0] value;

    // empty list: every positional request is out of range
    queue_req(ilie_pkg::KIND_READ,   0, 32'h0000_0000, 1'b0);
    queue_req(ilie_pkg::KIND_ERASE,  0, 32'hFFFF_FFFF, 1'b0);
    queue_req(ilie_pkg::KIND_INSERT, 1, 32'h1234_5678, 1'b0);
    // build a short list with extreme words, insert at front, middle and end
    queue_req(ilie_pkg::KIND_INSERT, 0, 32'h8000_0000, 1'b0);
    queue_req(ilie_pkg::KIND_APPEND, 0, 32'h7FFF_FFFF, 1'b0);
    queue_req(ilie_pkg::KIND_APPEND, 31, 32'hFFFF_FFFF, 1'b0);  // append ignores position
    queue_req(ilie_pkg::KIND_INSERT, 1, 32'h0000_0000, 1'b0);
    queue_req(ilie_pkg::KIND_INSERT, 4, 32'h5555_5555, 1'b0);
    queue_req(ilie_pkg::KIND_READ,   0, 32'h0000_0000, 1'b0);
    queue_req(ilie_pkg::KIND_READ,   4, 32'hAAAA_AAAA, 1'b0);
    // fill up to capacity
    for (int n = 5; n < ilie_pkg::DEPTH; n++)
      queue_req(ilie_pkg::KIND_APPEND, 0, $urandom, 1'b0);
    // full list: append and insert refused, out-of-range insert wins over full
    queue_req(ilie_pkg::KIND_APPEND, 0,  32'h0BAD_0BAD, 1'b0);
    queue_req(ilie_pkg::KIND_INSERT, 3,  32'h0BAD_0BAD, 1'b0);
    queue_req(ilie_pkg::KIND_INSERT, 17, 32'h0BAD_0BAD, 1'b0);
    queue_req(ilie_pkg::KIND_READ,   15, 32'h0000_0000, 1'b0);
    queue_req(ilie_pkg::KIND_READ,   31, 32'h0000_0000, 1'b0);
    queue_req(ilie_pkg::KIND_ERASE,  15, 32'h0000_0000, 1'b0);  // last entry
    queue_req(ilie_pkg::KIND_ERASE,  0,  32'h0000_0000, 1'b0);  // first entry
    queue_req(ilie_pkg::KIND_ERASE,  6,  32'h0000_0000, 1'b0);  // middle entry

    // random phases steer the size between empty and full
    phase_left = 0;
    phase_num  = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        mode       = gen_mode_t'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 80);
        phase_num++;
      end
      phase_left--;
      pick = $urandom_range(0, 99);
      case (mode)
        MIX_GROW:   kind = (pick < 40) ? ilie_pkg::KIND_APPEND :
                           (pick < 75) ? ilie_pkg::KIND_INSERT :
                           (pick < 85) ? ilie_pkg::KIND_ERASE : ilie_pkg::KIND_READ;
        MIX_SHRINK: kind = (pick < 10) ? ilie_pkg::KIND_APPEND :
                           (pick < 20) ? ilie_pkg::KIND_INSERT :
                           (pick < 75) ? ilie_pkg::KIND_ERASE : ilie_pkg::KIND_READ;
        default:    kind = pick[1:0];
      endcase
      // mostly low positions so short lists see valid requests too
      pick = $urandom_range(0, 99);
      pos  = (pick < 45) ? $urandom_range(0, 4) :
             (pick < 90) ? $urandom_range(0, ilie_pkg::DEPTH) : $urandom_range(0, 31);
      case ($urandom_range(0, 19))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7FFF_FFFF;
        2:       value = 32'hFFFF_FFFF;
        3:       value = 32'h0000_0000;
        default: value = $urandom;
      endcase
      // now and then the sender waits for everything outstanding to come back
      queue_req(kind, pos, value, (n == 0) || (phase_left == 0 && phase_num % 6 == 0));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
    if (awaited_results.size() != 0)
      flag_mismatch("results never returned", 64'(awaited_results.size()), '0);

    $display("requests: append %0d, insert %0d, erase %0d, read %0d; %0d results checked",
             kind_totals[ilie_pkg::KIND_APPEND], kind_totals[ilie_pkg::KIND_INSERT],
             kind_totals[ilie_pkg::KIND_ERASE], kind_totals[ilie_pkg::KIND_READ],
             results_checked);
    $display("outcomes: done %0d, out of range %0d, full %0d; %0d mismatches",
             status_totals[ilie_pkg::ST_DONE], status_totals[ilie_pkg::ST_RANGE],
             status_totals[ilie_pkg::ST_FULL], mismatch_count);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ilie_pkg.sv
rtl/ilie_ctrl.sv
rtl/ilie_datapath.sv
rtl/indexed_list_insert_erase_unit.sv
bench/indexed_list_insert_erase_unit_tb.sv
